>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted (active low).
`define DPQ_ASSERT(name, clk_s, rst_n_s, prop, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Assertion on the default clock and reset names of a checker.
`define DPQ_ASSERT_CLK(name, prop, msg) \
	`DPQ_ASSERT(name, clk, arst_n, prop, msg)

`endif

>>> hw/rtl/dpq_pkg.sv
// ----------------------------------------------------------------------------
// dpq_pkg
// Types and constants shared by the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

	localparam int VAL_W       = 32;
	localparam int CMD_W       = 2;
	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = CMD_W;
	localparam int M_TDATA_W   = 72;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_POP_MAX = 2'd1,
		CMD_POP_MIN = 2'd2
	} cmd_t;

	// One cell of the sorted chain.
	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
	} cell_t;

	// Broadcast to every cell for one accepted word.
	typedef struct packed {
		logic                    ins;
		logic                    pop_max;
		logic                    pop_min;
		logic signed [VAL_W-1:0] value;
	} ctrl_t;

endpackage

>>> hw/rtl/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded double-ended priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY signed 32-bit values, ascending from cell 0.
// Each input word is a command (insert, remove max, remove min); each yields
// one output word with the max, min, empty flag and an overflow flag. An
// insert into a full queue is dropped and flags overflow; removes from an
// empty queue do nothing; command code 3 is a no-op. Max and min read 0 when
// empty. On the accept edge every cell compares itself with the broadcast
// value and shifts toward or away from its neighbor at once; in the
// following cycle the max is picked out of the chain (AND-OR over all
// cells) into the output register. The next word is accepted on the edge
// where the result is taken, so the block takes no new word while one is
// in flight. Cell contents need no clearing after reset: only the valid
// bits are reset.
module double_ended_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: value[31:0]
	input  logic [dpq_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: command[1:0]
	input  logic [dpq_pkg::S_TUSER_W-1:0]   s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// m_tdata: max_value[31:0], min_value[63:32], is_empty[64], overflow[65],
	//          zero fill [71:66]
	output logic [dpq_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready
);

	dpq_pkg::cell_t                   cells    [CAPACITY];
	logic                             ins_here [CAPACITY];
	dpq_pkg::ctrl_t                   ctl;
	logic                             accept;
	logic                             full;
	logic                             drop;

	logic                             calc_q;     // chain updated, result forming
	logic                             m_tvalid_q;
	logic                             ovf_q;
	logic signed [dpq_pkg::VAL_W-1:0] max_q;
	logic signed [dpq_pkg::VAL_W-1:0] min_q;
	logic                             empty_q;

	logic signed [dpq_pkg::VAL_W-1:0] peek_max;
	logic signed [dpq_pkg::VAL_W-1:0] peek_min;
	logic                             peek_empty;

	// Output register frees up on the same edge it is taken.
	assign s_tready = !calc_q && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign full     = cells[CAPACITY-1].vld;

	// Command decode, broadcast to all cells.
	always_comb begin
		ctl.ins     = 1'b0;
		ctl.pop_max = 1'b0;
		ctl.pop_min = 1'b0;
		ctl.value   = $signed(s_tdata[dpq_pkg::VAL_W-1:0]);
		drop        = 1'b0;
		case (s_tuser)
			dpq_pkg::CMD_INSERT: begin
				ctl.ins = accept && !full;
				drop    = accept && full;
			end
			dpq_pkg::CMD_POP_MAX: begin
				ctl.pop_max = accept;
			end
			dpq_pkg::CMD_POP_MIN: begin
				ctl.pop_min = accept;
			end
			default: begin
				// unused code: no-op, still yields a result
			end
		endcase
	end

	// The chain: each cell sees its lower and upper neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		dpq_pkg::cell_t left_c;
		dpq_pkg::cell_t right_c;
		logic           left_ins_c;

		if (i == 0) begin : g_lo
			assign left_c     = '0;
			assign left_ins_c = 1'b0;
		end else begin : g_mid_lo
			assign left_c     = cells[i-1];
			assign left_ins_c = ins_here[i-1];
		end

		if (i == CAPACITY - 1) begin : g_hi
			assign right_c = '0;
		end else begin : g_mid_hi
			assign right_c = cells[i+1];
		end

		dpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left     (left_c),
			.left_ins (left_ins_c),
			.right    (right_c),
			.cur      (cells[i]),
			.ins_here (ins_here[i])
		);
	end

	dpq_peek #(
		.CAPACITY (CAPACITY)
	) u_peek (
		.cells     (cells),
		.max_value (peek_max),
		.min_value (peek_min),
		.is_empty  (peek_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			calc_q <= accept;
			if (calc_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_q <= drop;
		end
		if (calc_q) begin
			max_q   <= peek_empty ? '0 : peek_max;
			min_q   <= peek_min;
			empty_q <= peek_empty;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, ovf_q, empty_q, min_q, max_q};

endmodule

>>> hw/rtl/dpq_cell.sv
// ----------------------------------------------------------------------------
// dpq_cell
// One slot of the sorted chain: compares against the broadcast value and
// shifts with its neighbors.
// ----------------------------------------------------------------------------
module dpq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  dpq_pkg::ctrl_t ctl,
	input  dpq_pkg::cell_t left,
	input  logic           left_ins,
	input  dpq_pkg::cell_t right,
	output dpq_pkg::cell_t cur,
	output logic           ins_here
);

	logic                                 vld_q;
	logic signed [dpq_pkg::VAL_W-1:0]     val_q;

	// New value belongs here or lower: empty slot or we hold something larger.
	assign ins_here = !vld_q || (ctl.value < val_q);
	assign cur.vld  = vld_q;
	assign cur.val  = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.ins) begin
			if (left_ins) begin
				vld_q <= left.vld;
			end else if (ins_here) begin
				vld_q <= 1'b1;
			end
		end else if (ctl.pop_min) begin
			vld_q <= right.vld;
		end else if (ctl.pop_max) begin
			// top valid slot drops out
			vld_q <= vld_q && right.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_ins) begin
				val_q <= left.val;
			end else if (ins_here) begin
				val_q <= ctl.value;
			end
		end else if (ctl.pop_min) begin
			val_q <= right.val;
		end
	end

endmodule

>>> hw/rtl/dpq_peek.sv
// ----------------------------------------------------------------------------
// dpq_peek
// Reads the ends of the chain: lowest cell and topmost valid cell.
// ----------------------------------------------------------------------------
module dpq_peek #(
	parameter int CAPACITY = 64
) (
	input  dpq_pkg::cell_t                   cells [CAPACITY],
	output logic signed [dpq_pkg::VAL_W-1:0] max_value,
	output logic signed [dpq_pkg::VAL_W-1:0] min_value,
	output logic                             is_empty
);

	logic [CAPACITY-1:0] top;

	// one-hot marker of the last valid cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == CAPACITY - 1) begin
				top[i] = cells[i].vld;
			end else begin
				top[i] = cells[i].vld && !cells[i+1].vld;
			end
		end
	end

	always_comb begin
		max_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			max_value = max_value | (cells[i].val & {dpq_pkg::VAL_W{top[i]}});
		end
	end

	assign is_empty  = !cells[0].vld;
	assign min_value = cells[0].vld ? cells[0].val : '0;

endmodule

>>> hw/rtl/dpq_checker.sv
// ----------------------------------------------------------------------------
// dpq_checker
// Port-level checks for the double-ended priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic [dpq_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [dpq_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [dpq_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready
);

	// stalled result word holds
	`DPQ_ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")

	// one word in flight: no accept in the cycle after one
	`DPQ_ASSERT_CLK(a_one_busy, (s_tvalid && s_tready) |=> !s_tready, "input accepted back to back")

	// every accepted word is followed by a result word
	`DPQ_ASSERT_CLK(a_result, (s_tvalid && s_tready) |-> ##2 m_tvalid, "missing result word")

	// an empty queue reports zero ends
	`DPQ_ASSERT_CLK(a_empty_zero, (m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == 64'd0), "empty queue with nonzero ends")

	// a dropped insert means the queue was full
	`DPQ_ASSERT_CLK(a_ovf_full, m_tvalid |-> !(m_tdata[65] && m_tdata[64]), "overflow on empty queue")

endmodule

bind double_ended_priority_queue dpq_checker u_dpq_checker (.*);
